@@ rtl/core/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// Word layouts of the request and response channels, command and result
// codes, slot status codes and the table size.
// ----------------------------------------------------------------------------
package stt_pkg;

   // table size and derived widths
   localparam int TIMER_COUNT = 32;
   localparam int PTR_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int IDX_W       = 6;
   localparam int TIME_W      = 32;
   localparam int QUEUE_W     = 4;
   localparam int DATA_W      = 8;

   localparam logic [TIME_W-1:0] NO_EXPIRY = '1;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [IDX_W-1:0]   slot_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [QUEUE_W-1:0] queue_type;
   typedef logic [DATA_W-1:0]  data_type;

   // command codes
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_ALLOC = 3'd1,
      CMD_FREE  = 3'd2,
      CMD_BIND  = 3'd3,
      CMD_ARM   = 3'd4
   } cmd_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_GRANT   = 2'd0,
      KIND_FAIL    = 2'd1,
      KIND_EXPIRED = 2'd2
   } kind_type;

   // slot status codes
   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_ALLOC = 2'd1,
      ST_RUN   = 2'd2
   } status_type;

   // request word
   typedef struct packed {
      logic [2:0]  command;
      slot_type    timer_index;
      queue_type   queue_id;
      data_type    tag_data;
      time_type    delay_ticks;
   } req_type;

   // response word
   typedef struct packed {
      logic [1:0]  kind;
      slot_type    slot;
      queue_type   notify_queue;
      data_type    notify_data;
      logic        last;
   } rsp_type;

   // one table entry held in the slot memory
   typedef struct packed {
      time_type    expiry;
      queue_type   queue;
      data_type    data;
   } entry_type;

   // write request to the slot memory
   typedef struct packed {
      logic        exp_we;
      logic        bind_we;
      ptr_type     addr;
      entry_type   entry;
   } mem_wr_type;

endpackage

@@ rtl/core/stt_slot_mem.sv @@
// ----------------------------------------------------------------------------
// stt_slot_mem: per-slot expiry, queue and data storage
// One write port with separate enables for the expiry and the binding, one
// read port with registered read data.
// ----------------------------------------------------------------------------
module stt_slot_mem (
   input  logic                 clock,
   input  stt_pkg::mem_wr_type  wr,
   input  stt_pkg::ptr_type     rd_addr,
   output stt_pkg::entry_type   rd_entry
);

   stt_pkg::time_type  exp_mem   [stt_pkg::TIMER_COUNT];
   stt_pkg::queue_type queue_mem [stt_pkg::TIMER_COUNT];
   stt_pkg::data_type  data_mem  [stt_pkg::TIMER_COUNT];

   // write port
   always_ff @(posedge clock) begin
      if (wr.exp_we) begin
         exp_mem[wr.addr] <= wr.entry.expiry;
      end
      if (wr.bind_we) begin
         queue_mem[wr.addr] <= wr.entry.queue;
         data_mem[wr.addr]  <= wr.entry.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_entry.expiry <= exp_mem[rd_addr];
      rd_entry.queue  <= queue_mem[rd_addr];
      rd_entry.data   <= data_mem[rd_addr];
   end

endmodule

@@ rtl/core/software_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// software_timer_table_top: table of software timers with next-expiry cache
// Tick count stepped by tick commands, slot allocation, binding, arming and expiry scan.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and holds req_stall high until
// it has finished with it. Free and bind are done in S_IDLE, arm goes on
// through S_ARM, and alloc walks the slot status from slot 0 in S_ASCAN.
// A tick ends in S_TCHK when the count has not reached the cached next
// expiry; otherwise it scans every slot through the slot memory's registered
// read port, in S_SRD and then S_SEV for each slot, and rsp_stall can hold
// the scan back on an expiry word. Each expiry word is sent as the scan
// finds the next one, and the final word of a tick or an alloc carries last.
// Expiry compares are plain unsigned and do not handle wrap of the tick count.
module software_timer_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stt_pkg::rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TCHK,
      S_SRD,
      S_SEV,
      S_ASCAN,
      S_ARM,
      S_SEND
   } state_type;

   state_type              state_ff, state_in;
   stt_pkg::ptr_type       ptr_ff, ptr_in;
   stt_pkg::time_type      tick_ff, tick_in;
   stt_pkg::time_type      next_ff, next_in;
   stt_pkg::time_type      arm_sum_ff, arm_sum_in;
   stt_pkg::ptr_type       arm_idx_ff, arm_idx_in;
   stt_pkg::rsp_type       pend_ff, pend_in;
   logic                   pend_v_ff, pend_v_in;
   stt_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_v_ff, rsp_v_in;
   stt_pkg::status_type    status_ff [stt_pkg::TIMER_COUNT];
   stt_pkg::status_type    status_in [stt_pkg::TIMER_COUNT];

   stt_pkg::mem_wr_type    mem_wr;
   stt_pkg::entry_type     rd_entry;
   stt_pkg::time_type      addend;
   stt_pkg::time_type      sum;
   stt_pkg::ptr_type       req_ptr;
   logic                   req_fire;
   logic                   idx_ok;
   logic                   out_free;
   logic                   push;
   logic                   push_last;
   logic                   last_slot;
   logic                   tick_lt_exp;
   logic                   exp_lt_next;

   // slot memory
   stt_slot_mem u_mem (
      .clock    (clock),
      .wr       (mem_wr),
      .rd_addr  (ptr_ff),
      .rd_entry (rd_entry)
   );

   // handshake and common decode
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && (state_ff == S_IDLE);
   assign idx_ok    = (int'(req_data.timer_index) < stt_pkg::TIMER_COUNT);
   assign req_ptr   = req_data.timer_index[stt_pkg::PTR_W-1:0];
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign last_slot = (int'(ptr_ff) == stt_pkg::TIMER_COUNT - 1);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // shared adder: tick increment or arm expiry
   assign addend = (req_data.command == stt_pkg::CMD_TICK) ? stt_pkg::time_type'(1)
                                                            : req_data.delay_ticks;
   assign sum    = tick_ff + addend;

   // scan compares against the entry being visited
   assign tick_lt_exp = (tick_ff < rd_entry.expiry);
   assign exp_lt_next = (rd_entry.expiry < next_ff);

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      tick_in    = tick_ff;
      next_in    = next_ff;
      arm_sum_in = arm_sum_ff;
      arm_idx_in = arm_idx_ff;
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      status_in  = status_ff;
      push       = 1'b0;
      push_last  = 1'b0;

      mem_wr.exp_we       = 1'b0;
      mem_wr.bind_we      = 1'b0;
      mem_wr.addr         = req_ptr;
      mem_wr.entry.expiry = arm_sum_ff;
      mem_wr.entry.queue  = req_data.queue_id;
      mem_wr.entry.data   = req_data.tag_data;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.command)
                  stt_pkg::CMD_TICK: begin
                     tick_in  = sum;
                     state_in = S_TCHK;
                  end
                  stt_pkg::CMD_ALLOC: begin
                     ptr_in   = '0;
                     state_in = S_ASCAN;
                  end
                  stt_pkg::CMD_FREE: begin
                     if (idx_ok) begin
                        status_in[req_ptr] = stt_pkg::ST_FREE;
                     end
                  end
                  stt_pkg::CMD_BIND: begin
                     mem_wr.bind_we = idx_ok;
                  end
                  stt_pkg::CMD_ARM: begin
                     if (idx_ok) begin
                        arm_sum_in = sum;
                        arm_idx_in = req_ptr;
                        state_in   = S_ARM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // write the armed expiry and lower the cached next expiry
         S_ARM: begin
            mem_wr.exp_we         = 1'b1;
            mem_wr.addr           = arm_idx_ff;
            status_in[arm_idx_ff] = stt_pkg::ST_RUN;
            if (arm_sum_ff < next_ff) begin
               next_in = arm_sum_ff;
            end
            state_in = S_IDLE;
         end
         // has the count reached the cached next expiry
         S_TCHK: begin
            if (tick_ff < next_ff) begin
               state_in = S_IDLE;
            end else begin
               next_in   = stt_pkg::NO_EXPIRY;
               ptr_in    = '0;
               pend_v_in = 1'b0;
               state_in  = S_SRD;
            end
         end
         // entry read in flight
         S_SRD: begin
            state_in = S_SEV;
         end
         // evaluate one slot of the expiry scan
         S_SEV: begin
            if (status_ff[ptr_ff] == stt_pkg::ST_RUN && !tick_lt_exp) begin
               if (!pend_v_ff || out_free) begin
                  push                 = pend_v_ff;
                  pend_in.kind         = stt_pkg::KIND_EXPIRED;
                  pend_in.slot         = stt_pkg::slot_type'(ptr_ff);
                  pend_in.notify_queue = rd_entry.queue;
                  pend_in.notify_data  = rd_entry.data;
                  pend_in.last         = 1'b0;
                  pend_v_in            = 1'b1;
                  status_in[ptr_ff]    = stt_pkg::ST_ALLOC;
                  if (last_slot) begin
                     state_in = S_SEND;
                  end else begin
                     ptr_in   = ptr_ff + stt_pkg::ptr_type'(1);
                     state_in = S_SRD;
                  end
               end
            end else begin
               if (status_ff[ptr_ff] == stt_pkg::ST_RUN && exp_lt_next) begin
                  next_in = rd_entry.expiry;
               end
               if (last_slot) begin
                  state_in = S_SEND;
               end else begin
                  ptr_in   = ptr_ff + stt_pkg::ptr_type'(1);
                  state_in = S_SRD;
               end
            end
         end
         // lowest free slot search
         S_ASCAN: begin
            if (status_ff[ptr_ff] == stt_pkg::ST_FREE) begin
               status_in[ptr_ff]    = stt_pkg::ST_ALLOC;
               pend_in.kind         = stt_pkg::KIND_GRANT;
               pend_in.slot         = stt_pkg::slot_type'(ptr_ff);
               pend_in.notify_queue = '0;
               pend_in.notify_data  = '0;
               pend_in.last         = 1'b0;
               pend_v_in            = 1'b1;
               state_in             = S_SEND;
            end else if (last_slot) begin
               pend_in.kind         = stt_pkg::KIND_FAIL;
               pend_in.slot         = '0;
               pend_in.notify_queue = '0;
               pend_in.notify_data  = '0;
               pend_in.last         = 1'b0;
               pend_v_in            = 1'b1;
               state_in             = S_SEND;
            end else begin
               ptr_in = ptr_ff + stt_pkg::ptr_type'(1);
            end
         end
         // send the held word as the final one
         S_SEND: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in   = rsp_ff;
      rsp_v_in = rsp_v_ff;
      if (push) begin
         rsp_in      = pend_ff;
         rsp_in.last = push_last;
         rsp_v_in    = 1'b1;
      end else if (!rsp_stall) begin
         rsp_v_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ptr_ff    <= '0;
         tick_ff   <= '0;
         next_ff   <= stt_pkg::NO_EXPIRY;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int i = 0; i < stt_pkg::TIMER_COUNT; i++) begin
            status_ff[i] <= stt_pkg::ST_FREE;
         end
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         tick_ff   <= tick_in;
         next_ff   <= next_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         status_ff <= status_in;
      end
      arm_sum_ff <= arm_sum_in;
      arm_idx_ff <= arm_idx_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

endmodule
